[rtl/core/flagged_frame_deframer_crc8_assert.svh]
// Assertion macros for the flagged frame deframer.
`ifndef FLAGGED_FRAME_DEFRAMER_CRC8_ASSERT_SVH
`define FLAGGED_FRAME_DEFRAMER_CRC8_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FFD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/ffd_crc8_pkg.sv]
// Constants and CRC-8 helper shared by the flagged frame deframer.
`default_nettype none

package ffd_crc8_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;
    localparam logic [7:0] CRC_TAP     = 8'h18;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 32;

    typedef logic [7:0] t_byte;

    // Dallas/Maxim CRC-8, one byte, LSB first
    function automatic t_byte crc_add(input t_byte crc_in, input t_byte data_in);
        t_byte c;
        t_byte b;
        logic  fb;
        c = crc_in;
        b = data_in;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[0];
            if (fb) begin
                c = c ^ CRC_TAP;
            end
            c = {fb, c[7:1]};
            b = {1'b0, b[7:1]};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/core/flagged_frame_deframer_crc8.sv]
// Flagged frame deframer with sync pair hunt and Dallas/Maxim CRC-8 check.
// Takes one received byte per transaction and can accept a byte every clock cycle; each
// result appears on the master side in the cycle after its input transaction, held in a
// single output register. The slave side stalls only while that register holds a result
// the master side has not yet taken. o_m_tuser is 0 for a passed-through payload byte and
// 1 for the end-of-frame report carried on the CRC byte.
`default_nettype none

`include "flagged_frame_deframer_crc8_assert.svh"

module flagged_frame_deframer_crc8 (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire  [ffd_crc8_pkg::IN_TDATA_W-1:0]     i_s_tdata,  // [7:0] rx_byte
    output logic                                    o_m_tvalid,
    input  wire                                     i_m_tready,
    output logic [ffd_crc8_pkg::OUT_TDATA_W-1:0]    o_m_tdata,  // [7:0] payload_byte,
                                                                // [15:8] frame_opcode,
                                                                // [23:16] frame_length,
                                                                // [24] crc_ok, [31:25] zero
    output logic                                    o_m_tuser   // [0] kind
);

    localparam logic [2:0] PH_HUNT1   = 3'd0;
    localparam logic [2:0] PH_HUNT2   = 3'd1;
    localparam logic [2:0] PH_OPCODE  = 3'd2;
    localparam logic [2:0] PH_LENGTH  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CRC     = 3'd5;

    logic [2:0] r_phase, n_phase;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_crc, n_crc;
    logic [7:0] r_opcode, n_opcode;
    logic [7:0] r_length, n_length;

    logic       r_out_valid, n_out_valid;
    logic       r_out_kind, n_out_kind;
    logic [7:0] r_out_pay, n_out_pay;
    logic       r_out_ok, n_out_ok;
    logic [7:0] r_out_opc, n_out_opc;
    logic [7:0] r_out_len, n_out_len;

    logic       w_acc;
    logic       w_emit;
    logic [7:0] w_rx;
    logic [7:0] w_crc_seed;
    logic [7:0] w_crc_upd;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_rx       = i_s_tdata;

    // a first flag seen while hunting always restarts the CRC from zero
    assign w_crc_seed = ((r_phase == PH_HUNT1) ||
                         ((r_phase == PH_HUNT2) && (w_rx == ffd_crc8_pkg::SYNC_FIRST)))
                        ? 8'h00 : r_crc;
    assign w_crc_upd  = ffd_crc8_pkg::crc_add(w_crc_seed, w_rx);

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        n_opcode     = r_opcode;
        n_length     = r_length;
        w_emit       = 1'b0;
        n_out_kind   = 1'b0;
        n_out_pay    = 8'h00;
        n_out_ok     = 1'b0;
        unique case (r_phase)
            PH_HUNT1: begin
                if (w_rx == ffd_crc8_pkg::SYNC_FIRST) begin
                    n_crc   = w_crc_upd;
                    n_phase = PH_HUNT2;
                end else begin
                    n_crc = 8'h00;
                end
            end
            PH_HUNT2: begin
                if (w_rx == ffd_crc8_pkg::SYNC_SECOND) begin
                    n_crc   = w_crc_upd;
                    n_phase = PH_OPCODE;
                end else if (w_rx == ffd_crc8_pkg::SYNC_FIRST) begin
                    n_crc = w_crc_upd;
                end else begin
                    n_crc   = 8'h00;
                    n_phase = PH_HUNT1;
                end
            end
            PH_OPCODE: begin
                n_opcode = w_rx;
                n_crc    = w_crc_upd;
                n_phase  = PH_LENGTH;
            end
            PH_LENGTH: begin
                n_length     = w_rx;
                n_bytes_left = w_rx;
                n_crc        = w_crc_upd;
                n_phase      = (w_rx == 8'h00) ? PH_CRC : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_crc        = w_crc_upd;
                n_bytes_left = r_bytes_left - 8'd1;
                if (r_bytes_left == 8'd1) begin
                    n_phase = PH_CRC;
                end
                w_emit    = 1'b1;
                n_out_pay = w_rx;
            end
            PH_CRC: begin
                w_emit       = 1'b1;
                n_out_kind   = 1'b1;
                n_out_ok     = (w_rx == r_crc);
                n_crc        = 8'h00;
                n_bytes_left = 8'h00;
                n_phase      = PH_HUNT1;
            end
            default: begin
                n_crc        = 8'h00;
                n_bytes_left = 8'h00;
                n_phase      = PH_HUNT1;
            end
        endcase
        n_out_opc = n_opcode;
        n_out_len = n_length;
    end

    always_comb begin
        if (w_acc && w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT1;
            r_bytes_left <= 8'h00;
            r_crc        <= 8'h00;
            r_opcode     <= 8'h00;
            r_length     <= 8'h00;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_acc) begin
                r_phase      <= n_phase;
                r_bytes_left <= n_bytes_left;
                r_crc        <= n_crc;
                r_opcode     <= n_opcode;
                r_length     <= n_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_emit) begin
            r_out_kind <= n_out_kind;
            r_out_pay  <= n_out_pay;
            r_out_ok   <= n_out_ok;
            r_out_opc  <= n_out_opc;
            r_out_len  <= n_out_len;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {7'b0, r_out_ok, r_out_len, r_out_opc, r_out_pay};

    `FFD_ASSERT_NXT(a_payload_emits, w_acc && (r_phase == PH_PAYLOAD), o_m_tvalid && !o_m_tuser, "payload byte did not produce a kind-0 result")
    `FFD_ASSERT_NXT(a_crc_closes_frame, w_acc && (r_phase == PH_CRC), o_m_tvalid && o_m_tuser && (r_phase == PH_HUNT1) && (r_crc == 8'h00), "CRC byte did not report and return to hunting")
    `FFD_ASSERT_IMP(a_payload_count, r_phase == PH_PAYLOAD, r_bytes_left != 8'h00, "payload phase with no bytes left")

endmodule

`default_nettype wire
